// ===== src/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// acp_pkg: shared types and constants of the attitude PID core
// Holds fixed-point limits, register indexes, the gain bank type and the
// control word that the sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int ACCEL_LIMIT    = 16384;
  localparam int INTEGRAL_LIMIT = 1048576;
  localparam int VERTICAL_GUARD = 14563;
  localparam int STEP_SHIFT     = 8;
  localparam int FRAC_SHIFT     = 8 + STEP_SHIFT;

  localparam int GAIN_W  = 16;
  localparam int DATA_W  = 16;
  localparam int INTEG_W = 32;
  localparam int OPD_W   = 33;
  localparam int PROD_W  = GAIN_W + 1 + OPD_W;
  localparam int ACC_W   = 58;

  localparam int CFG_IDX_W = 8;
  localparam int NUM_REGS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_P = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_D = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_I = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_YAW_P   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_YAW_D   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_YAW_I   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_P  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_D  = CFG_IDX_W'(7);

  typedef enum logic [1:0] {
    AX_ROLL,
    AX_PITCH,
    AX_YAW
  } axis_e;

  typedef struct packed {
    logic [GAIN_W-1:0] pitch_p;
    logic [GAIN_W-1:0] pitch_d;
    logic [GAIN_W-1:0] pitch_i;
    logic [GAIN_W-1:0] yaw_p;
    logic [GAIN_W-1:0] yaw_d;
    logic [GAIN_W-1:0] yaw_i;
    logic [GAIN_W-1:0] roll_p;
    logic [GAIN_W-1:0] roll_d;
  } gains_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    logic  neg;
    logic  scale;
    axis_e axis;
  } mac_ctrl_t;

endpackage

// ===== src/three_axis_attitude_pid_core.sv =====
// ----------------------------------------------------------------------------
// three_axis_attitude_pid_core: three-axis attitude PID controller
// Sequences eight multiply-accumulate steps per control tick through one
// shared multiplier and keeps the pitch and yaw integrators.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         one control tick: angles, rates, targets
//  m_axis    out        roll, pitch and yaw accelerations, guard flag
//  cfg       in         gain register writes, index and 16-bit value
//
//  A tick occupies the block from acceptance while the step counter drives
//  the shared multiplier and its two-stage accumulate path, and then until
//  the output register is loaded.
//  Reset clears the gains to their defaults and both integrators to zero.
//  A stalled output holds its result; a new request is taken meanwhile and
//  waits at its end until the output register frees.
// ----------------------------------------------------------------------------
module three_axis_attitude_pid_core import acp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // roll_angle, pitch_angle, heading_angle, roll_rate, pitch_rate, yaw_rate,
  // pitch_target, heading_target, roll_target
  input  logic [143:0]         s_axis_tdata,
  // pitch_target_valid, heading_target_valid, roll_target_valid
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // roll_accel, pitch_accel, yaw_accel
  output logic [47:0]          m_axis_tdata,
  // guard_active
  output logic [0:0]           m_axis_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_ISSUE = STEP_W'(7);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(9);
  localparam logic signed [INTEG_W:0] IntLimPos = (INTEG_W+1)'(INTEGRAL_LIMIT);
  localparam logic signed [INTEG_W:0] IntLimNeg = -(INTEG_W+1)'(INTEGRAL_LIMIT);

  gains_t gains;

  state_e             state_q;
  logic [STEP_W-1:0]  step_q;
  logic               m_valid_q;
  logic [47:0]        m_data_q;
  logic               m_guard_q;

  logic signed [16:0]        e_pitch_q;
  logic signed [DATA_W-1:0]  e_yaw_q, e_roll_q;
  logic signed [DATA_W-1:0]  p_q, q_q, r_q;
  logic                      guard_q;
  logic signed [INTEG_W-1:0] pint_q, yint_q;
  logic signed [DATA_W-1:0]  roll_res_q, pitch_res_q, yaw_res_q;

  logic signed [DATA_W-1:0] in_roll, in_pitch, in_head, in_pt, in_ht, in_rt;
  logic signed [16:0]       pitch_ext, pitch_abs, e_pitch_d;
  logic                     guard_d;
  logic signed [DATA_W-1:0] rt_sel;

  logic                     accept;
  logic                     out_load;
  logic                     integ_step;
  logic signed [INTEG_W:0]  pint_sum, yint_sum;
  logic signed [INTEG_W-1:0] pint_d, yint_d;

  mac_ctrl_t                mac_ctrl;
  logic [GAIN_W-1:0]        mac_gain;
  logic signed [OPD_W-1:0]  mac_opd;
  logic                     res_valid;
  axis_e                    res_axis;
  logic signed [DATA_W-1:0] res;

  acp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .gains_o     (gains)
  );

  acp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .gain_i      (mac_gain),
    .opd_i       (mac_opd),
    .res_valid_o (res_valid),
    .res_axis_o  (res_axis),
    .res_o       (res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_guard_q;

  // Error terms and the vertical guard are formed once at acceptance.
  always_comb begin
    in_roll   = s_axis_tdata[15:0];
    in_pitch  = s_axis_tdata[31:16];
    in_head   = s_axis_tdata[47:32];
    in_pt     = s_axis_tdata[111:96];
    in_ht     = s_axis_tdata[127:112];
    in_rt     = s_axis_tdata[143:128];
    pitch_ext = {in_pitch[15], in_pitch};
    pitch_abs = in_pitch[15] ? -pitch_ext : pitch_ext;
    guard_d   = pitch_abs > 17'(VERTICAL_GUARD);
    e_pitch_d = s_axis_tuser[0] ? ({in_pt[15], in_pt} - pitch_ext) : '0;
    rt_sel    = s_axis_tuser[2] ? in_rt : '0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_pitch_q <= e_pitch_d;
      e_yaw_q   <= (s_axis_tuser[1] && !guard_d) ? (in_ht - in_head) : '0;
      e_roll_q  <= guard_d ? '0 : (rt_sel - in_roll);
      p_q       <= s_axis_tdata[63:48];
      q_q       <= s_axis_tdata[79:64];
      r_q       <= s_axis_tdata[95:80];
      guard_q   <= guard_d;
    end
  end

  // Integrators advance in the first step, ahead of their use; the yaw integrator holds while the guard is active.
  assign integ_step = (state_q == ST_RUN) && (step_q == '0);

  always_comb begin
    pint_sum = {pint_q[INTEG_W-1], pint_q} + (INTEG_W+1)'(e_pitch_q);
    yint_sum = {yint_q[INTEG_W-1], yint_q} + (INTEG_W+1)'(e_yaw_q);
    if (pint_sum > IntLimPos) begin
      pint_d = INTEG_W'(IntLimPos);
    end else if (pint_sum < IntLimNeg) begin
      pint_d = INTEG_W'(IntLimNeg);
    end else begin
      pint_d = INTEG_W'(pint_sum);
    end
    if (yint_sum > IntLimPos) begin
      yint_d = INTEG_W'(IntLimPos);
    end else if (yint_sum < IntLimNeg) begin
      yint_d = INTEG_W'(IntLimNeg);
    end else begin
      yint_d = INTEG_W'(yint_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pint_q <= '0;
      yint_q <= '0;
    end else if (integ_step) begin
      pint_q <= pint_d;
      if (!guard_q) begin
        yint_q <= yint_d;
      end
    end
  end

  // Step program for the shared multiplier.
  always_comb begin
    mac_ctrl       = '0;
    mac_ctrl.axis  = AX_PITCH;
    mac_ctrl.valid = (state_q == ST_RUN) && (step_q <= LAST_ISSUE);
    mac_gain       = '0;
    mac_opd        = '0;
    case (step_q[2:0])
      3'd0: begin
        mac_gain = gains.pitch_p; mac_opd = OPD_W'(e_pitch_q);
        mac_ctrl.first = 1'b1; mac_ctrl.scale = 1'b1;
      end
      3'd1: begin
        mac_gain = gains.pitch_d; mac_opd = OPD_W'(q_q);
        mac_ctrl.neg = 1'b1; mac_ctrl.scale = 1'b1;
      end
      3'd2: begin
        mac_gain = gains.pitch_i; mac_opd = OPD_W'(pint_q);
        mac_ctrl.last = 1'b1;
      end
      3'd3: begin
        mac_gain = gains.yaw_p; mac_opd = OPD_W'(e_yaw_q);
        mac_ctrl.first = 1'b1; mac_ctrl.scale = 1'b1; mac_ctrl.axis = AX_YAW;
      end
      3'd4: begin
        mac_gain = gains.yaw_d; mac_opd = OPD_W'(r_q);
        mac_ctrl.neg = 1'b1; mac_ctrl.scale = 1'b1; mac_ctrl.axis = AX_YAW;
      end
      3'd5: begin
        mac_gain = gains.yaw_i; mac_opd = guard_q ? '0 : OPD_W'(yint_q);
        mac_ctrl.last = 1'b1; mac_ctrl.axis = AX_YAW;
      end
      3'd6: begin
        mac_gain = gains.roll_p; mac_opd = OPD_W'(e_roll_q);
        mac_ctrl.first = 1'b1; mac_ctrl.scale = 1'b1; mac_ctrl.axis = AX_ROLL;
      end
      default: begin
        mac_gain = gains.roll_d; mac_opd = OPD_W'(p_q);
        mac_ctrl.neg = 1'b1; mac_ctrl.scale = 1'b1; mac_ctrl.last = 1'b1;
        mac_ctrl.axis = AX_ROLL;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      case (res_axis)
        AX_ROLL:  roll_res_q  <= res;
        AX_YAW:   yaw_res_q   <= res;
        default:  pitch_res_q <= res;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_guard_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (accept) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == LAST_STEP) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_data_q  <= {yaw_res_q, pitch_res_q, roll_res_q};
            m_guard_q <= guard_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/acp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acp_cfg_regs: gain register bank
// Eight 16-bit unsigned Q8.8 gains written through the configuration
// channel. Writes to indexes beyond the bank are dropped.
// ----------------------------------------------------------------------------
module acp_cfg_regs import acp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  output gains_t               gains_o
);

  gains_t gains_q, gains_d;

  assign cfg_ready_o = 1'b1;
  assign gains_o     = gains_q;

  always_comb begin
    gains_d = gains_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PITCH_P: gains_d.pitch_p = cfg_data_i;
        REG_PITCH_D: gains_d.pitch_d = cfg_data_i;
        REG_PITCH_I: gains_d.pitch_i = cfg_data_i;
        REG_YAW_P:   gains_d.yaw_p   = cfg_data_i;
        REG_YAW_D:   gains_d.yaw_d   = cfg_data_i;
        REG_YAW_I:   gains_d.yaw_i   = cfg_data_i;
        REG_ROLL_P:  gains_d.roll_p  = cfg_data_i;
        REG_ROLL_D:  gains_d.roll_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '{pitch_p: GAIN_W'(256), pitch_d: '0, pitch_i: '0,
                   yaw_p: GAIN_W'(256), yaw_d: '0, yaw_i: '0,
                   roll_p: GAIN_W'(256), roll_d: '0};
    end else begin
      gains_q <= gains_d;
    end
  end

endmodule

// ===== src/acp_mac.sv =====
// ----------------------------------------------------------------------------
// acp_mac: shared multiply-accumulate unit
// One registered 17x33 signed multiply, an accumulate stage, and a floor
// shift with saturation that presents each finished axis acceleration.
// ----------------------------------------------------------------------------
module acp_mac import acp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic signed [OPD_W-1:0] opd_i,
  output logic                    res_valid_o,
  output axis_e                   res_axis_o,
  output logic signed [DATA_W-1:0] res_o
);

  localparam logic signed [ACC_W-1:0] LimPos = ACC_W'(ACCEL_LIMIT);
  localparam logic signed [ACC_W-1:0] LimNeg = -ACC_W'(ACCEL_LIMIT);

  mac_ctrl_t                 c1_q, c2_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   term_ext, term, base, shifted;
  logic signed [GAIN_W:0]    gain_s;

  assign gain_s = $signed({1'b0, gain_i});
  assign prod_d = gain_s * opd_i;

  always_comb begin
    term_ext = ACC_W'(prod_q);
    term     = c1_q.scale ? (term_ext <<< STEP_SHIFT) : term_ext;
    base     = c1_q.first ? '0 : acc_q;
    acc_d    = c1_q.neg ? (base - term) : (base + term);
  end

  always_comb begin
    shifted = acc_q >>> FRAC_SHIFT;
    if (shifted > LimPos) begin
      res_o = DATA_W'(LimPos);
    end else if (shifted < LimNeg) begin
      res_o = DATA_W'(LimNeg);
    end else begin
      res_o = DATA_W'(shifted);
    end
  end

  assign res_valid_o = c2_q.valid & c2_q.last;
  assign res_axis_o  = c2_q.axis;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= prod_d;
    end
    if (c1_q.valid) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== src/acp_checker.sv =====
// ----------------------------------------------------------------------------
// acp_checker: port-level checks for the attitude PID core
// Watches the input and output stream ports over time and is bound to the
// top level.
// ----------------------------------------------------------------------------
module acp_checker import acp_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  logic signed [15:0] roll_a, pitch_a, yaw_a;

  assign roll_a  = m_axis_tdata[15:0];
  assign pitch_a = m_axis_tdata[31:16];
  assign yaw_a   = m_axis_tdata[47:32];

  // The block drops input ready right after taking a request and stays busy for the tick.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_accel_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      roll_a <= 16'(ACCEL_LIMIT) && roll_a >= -16'(ACCEL_LIMIT) &&
      pitch_a <= 16'(ACCEL_LIMIT) && pitch_a >= -16'(ACCEL_LIMIT) &&
      yaw_a <= 16'(ACCEL_LIMIT) && yaw_a >= -16'(ACCEL_LIMIT))
    else $error("acceleration outside the saturation limit");

  // A new result only appears at the end of a tick, while input is blocked.
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a tick in progress");

endmodule

bind three_axis_attitude_pid_core acp_checker u_acp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_three_axis_attitude_pid_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_axis_attitude_pid_core: self-checking bench of the attitude PID core
// Drives control ticks over the input stream and gain writes over the config
// channel. Each accepted tick is run through a bit-accurate model of the
// three axis laws and the two integrators, and every result on the output
// stream is compared field by field in order. A short table of hand-computed
// ticks comes first; random ticks under several gain banks and handshake
// pressure patterns follow.
// ----------------------------------------------------------------------------
module tb_three_axis_attitude_pid_core;
  import acp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] head;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] pitch_tgt;
    logic               pitch_ok;
    logic signed [15:0] head_tgt;
    logic               head_ok;
    logic signed [15:0] roll_tgt;
    logic               roll_ok;
  } tick_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               guard;
  } accel_t;

  typedef struct {
    tick_t  t;
    accel_t want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [143:0]         s_axis_tdata;
  logic [2:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [47:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  gains_t   gain_bank;
  longint   pitch_integ = 0;
  longint   yaw_integ = 0;
  accel_t   pending_accel[$];
  row_t     plan[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_left = 0;
  int       tick_count = 0;

  three_axis_attitude_pid_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint wrap_turn(longint d);
    logic signed [15:0] w;
    w = d[15:0];
    return longint'(w);
  endfunction

  function automatic longint axis_accel(longint kp, longint e, longint kd, longint rate,
                                        longint ki, longint integ);
    longint sum;
    sum = (kp * e - kd * rate) * (longint'(1) <<< STEP_SHIFT) + ki * integ;
    return clamp_sym(sum >>> FRAC_SHIFT, ACCEL_LIMIT);
  endfunction

  function automatic accel_t attitude_law(tick_t t);
    accel_t a;
    longint e;
    longint mag;
    e = t.pitch_ok ? longint'(t.pitch_tgt) - longint'(t.pitch) : 0;
    pitch_integ = clamp_sym(pitch_integ + e, INTEGRAL_LIMIT);
    a.pitch = 16'(axis_accel(gain_bank.pitch_p, e, gain_bank.pitch_d, t.pitch_rate,
                             gain_bank.pitch_i, pitch_integ));
    mag = (t.pitch < 0) ? -longint'(t.pitch) : longint'(t.pitch);
    a.guard = (mag > VERTICAL_GUARD);
    if (a.guard) begin
      a.yaw  = 16'(axis_accel(0, 0, gain_bank.yaw_d, t.yaw_rate, 0, 0));
      a.roll = 16'(axis_accel(0, 0, gain_bank.roll_d, t.roll_rate, 0, 0));
    end else begin
      e = t.head_ok ? wrap_turn(longint'(t.head_tgt) - longint'(t.head)) : 0;
      yaw_integ = clamp_sym(yaw_integ + e, INTEGRAL_LIMIT);
      a.yaw = 16'(axis_accel(gain_bank.yaw_p, e, gain_bank.yaw_d, t.yaw_rate,
                             gain_bank.yaw_i, yaw_integ));
      e = wrap_turn((t.roll_ok ? longint'(t.roll_tgt) : 0) - longint'(t.roll));
      a.roll = 16'(axis_accel(gain_bank.roll_p, e, gain_bank.roll_d, t.roll_rate, 0, 0));
    end
    return a;
  endfunction

  function automatic tick_t random_tick(int drift);
    tick_t t;
    int    v;
    if ($urandom_range(0, 4) == 0) begin
      t.roll       = 16'($urandom);
      t.pitch      = 16'($urandom);
      t.head       = 16'($urandom);
      t.roll_rate  = 16'($urandom);
      t.pitch_rate = 16'($urandom);
      t.yaw_rate   = 16'($urandom);
      t.pitch_tgt  = 16'($urandom);
      t.head_tgt   = 16'($urandom);
      t.roll_tgt   = 16'($urandom);
      t.pitch_ok   = 1'($urandom);
      t.head_ok    = 1'($urandom);
      t.roll_ok    = 1'($urandom);
    end else begin
      t.pitch = 16'(int'($urandom_range(0, 32767)) - 16384);
      v = int'(t.pitch) + drift * int'($urandom_range(0, 32000));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      t.pitch_tgt  = 16'(v);
      t.head       = 16'($urandom);
      t.head_tgt   = 16'(int'(t.head) + drift * int'($urandom_range(0, 32000)));
      t.roll       = 16'(int'($urandom_range(0, 16000)) - 8000);
      t.roll_tgt   = 16'(int'($urandom_range(0, 16000)) - 8000);
      t.roll_rate  = 16'(int'($urandom_range(0, 4000)) - 2000);
      t.pitch_rate = 16'(int'($urandom_range(0, 4000)) - 2000);
      t.yaw_rate   = 16'(int'($urandom_range(0, 4000)) - 2000);
      t.pitch_ok   = ($urandom_range(0, 9) != 0);
      t.head_ok    = ($urandom_range(0, 9) != 0);
      t.roll_ok    = ($urandom_range(0, 4) != 0);
    end
    return t;
  endfunction

  function automatic gains_t random_bank();
    gains_t g;
    logic [8*GAIN_W-1:0] flat;
    for (int i = 0; i < 8; i++) begin
      flat[i*GAIN_W +: GAIN_W] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 700));
    end
    g = gains_t'(flat);
    return g;
  endfunction

  task automatic add_row(int roll, int pitch, int head, int p, int q, int r,
                         int pt, bit pok, int ht, bit hok, int rt, bit rok,
                         int a_roll, int a_pitch, int a_yaw, bit guard);
    row_t row;
    row.t.roll       = 16'(roll);
    row.t.pitch      = 16'(pitch);
    row.t.head       = 16'(head);
    row.t.roll_rate  = 16'(p);
    row.t.pitch_rate = 16'(q);
    row.t.yaw_rate   = 16'(r);
    row.t.pitch_tgt  = 16'(pt);
    row.t.pitch_ok   = pok;
    row.t.head_tgt   = 16'(ht);
    row.t.head_ok    = hok;
    row.t.roll_tgt   = 16'(rt);
    row.t.roll_ok    = rok;
    row.want.roll    = 16'(a_roll);
    row.want.pitch   = 16'(a_pitch);
    row.want.yaw     = 16'(a_yaw);
    row.want.guard   = guard;
    plan.insert(plan.size(), row);
  endtask

  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_PITCH_P: gain_bank.pitch_p = val;
      REG_PITCH_D: gain_bank.pitch_d = val;
      REG_PITCH_I: gain_bank.pitch_i = val;
      REG_YAW_P:   gain_bank.yaw_p   = val;
      REG_YAW_D:   gain_bank.yaw_d   = val;
      REG_YAW_I:   gain_bank.yaw_i   = val;
      REG_ROLL_P:  gain_bank.roll_p  = val;
      REG_ROLL_D:  gain_bank.roll_d  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_gains(gains_t g);
    write_gain(REG_PITCH_P, g.pitch_p);
    write_gain(REG_PITCH_D, g.pitch_d);
    write_gain(REG_PITCH_I, g.pitch_i);
    write_gain(REG_YAW_P, g.yaw_p);
    write_gain(REG_YAW_D, g.yaw_d);
    write_gain(REG_YAW_I, g.yaw_i);
    write_gain(REG_ROLL_P, g.roll_p);
    write_gain(REG_ROLL_D, g.roll_d);
    // Writes beyond the register file must leave the gains alone.
    write_gain('1, 16'($urandom));
    write_gain(CFG_IDX_W'($urandom_range(NUM_REGS, 254)), 16'($urandom));
  endtask

  task automatic offer_tick(tick_t t, bit typed, accel_t want);
    accel_t got;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.roll_tgt, t.head_tgt, t.pitch_tgt, t.yaw_rate, t.pitch_rate,
                      t.roll_rate, t.head, t.pitch, t.roll};
    s_axis_tuser  <= {t.roll_ok, t.head_ok, t.pitch_ok};
    do @(posedge clk_i); while (!s_axis_tready);
    got = attitude_law(t);
    pending_accel.insert(pending_accel.size(), typed ? want : got);
    tick_count++;
  endtask

  task automatic drain_ticks();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_accel.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int items, int idle_pct, int stall_pct, bit squeeze);
    accel_t none;
    none = '{default: '0};
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < items; k++) begin
      if (squeeze && k == 30) hold_left = 200;
      if (squeeze && k == 60) drain_ticks();
      offer_tick(random_tick(((tick_count / 80) % 2) ? -1 : 1), 1'b0, none);
    end
    drain_ticks();
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : accel_monitor
    accel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_accel.size() == 0) begin
        $display("%0t: result with none expected, actual %h / %b", $time, m_axis_tdata,
                 m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_accel.pop_front();
        check_field("roll_accel", want.roll, m_axis_tdata[15:0]);
        check_field("pitch_accel", want.pitch, m_axis_tdata[31:16]);
        check_field("yaw_accel", want.yaw, m_axis_tdata[47:32]);
        check_field("guard_active", 16'(want.guard), 16'(m_axis_tuser[0]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_three_axis_attitude_pid_core: errors");
      $finish;
    end
  end

  initial begin
    gains_t bank;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    gain_bank = '{pitch_p: 16'd256, pitch_d: 16'd0, pitch_i: 16'd0,
                  yaw_p: 16'd256, yaw_d: 16'd0, yaw_i: 16'd0,
                  roll_p: 16'd256, roll_d: 16'd0};

    // With unit P and D gains and no integral gain each axis gives
    // sat(error - rate), and in guard mode roll and yaw give sat(-rate).
    //      roll    pitch   head    p       q       r       pt     pok ht     hok rt   rok
    add_row(0,      0,      0,      0,      0,      0,      0,     0,  0,     0,  0,   0,
            0,      0,      0,      0);
    add_row(0,      -32768, 0,      -32768, 0,      32767,  32767, 1,  0,     0,  0,   0,
            16384,  16384,  -16384, 1);
    add_row(0,      32767,  0,      32767,  32767,  -32768, -32768, 1, 0,     0,  0,   0,
            -16384, -16384, 16384,  1);
    add_row(0,      14563,  0,      0,      0,      0,      0,     0,  100,   1,  -200, 1,
            -200,   0,      100,    0);
    add_row(0,      14564,  0,      0,      0,      0,      0,     0,  100,   1,  -200, 1,
            0,      0,      0,      1);
    add_row(0,      -14563, 0,      0,      0,      0,      0,     0,  100,   1,  -200, 1,
            -200,   0,      100,    0);
    add_row(0,      -14564, 0,      0,      0,      0,      0,     0,  100,   1,  -200, 1,
            0,      0,      0,      1);
    add_row(0,      0,      -32768, 0,      0,      0,      0,     0,  0,     1,  -32768, 1,
            -16384, 0,      -16384, 0);
    add_row(-32768, 0,      -32768, 0,      0,      0,      0,     0,  32767, 1,  1234, 0,
            -16384, 0,      -1,     0);
    add_row(50,     1000,   300,    0,      0,      0,      9000,  0,  5000,  0,  -700, 0,
            -50,    0,      0,      0);
    add_row(100,    1000,   -1000,  300,    500,    -250,   3000,  1,  1000,  1,  400, 1,
            0,      1500,   2250,   0);
    add_row(32767,  0,      32767,  0,      -32768, 0,      -1,    1,  -32768, 1, 0,   0,
            -16384, 16384,  1,      0);
    add_row(-1,     0,      0,      0,      0,      -1,     0,     0,  32767, 1,  32767, 1,
            -16384, 0,      16384,  0);
    add_row(0,      0,      0,      0,      0,      0,      16385, 1,  16384, 1,  -16385, 1,
            -16384, 16384,  16384,  0);
    add_row(0,      0,      0,      0,      0,      0,      -16384, 1, -16383, 1, 16383, 1,
            16383,  -16384, -16383, 0);
    add_row(0,      -20000, 0,      7,      0,      -5,     -20000, 1, 3000,  1,  3000, 1,
            -7,     0,      5,      1);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_gain(REG_PITCH_D, 16'd256);
    write_gain(REG_YAW_D, 16'd256);
    write_gain(REG_ROLL_D, 16'd256);
    send_idle_pct  = 6;
    recv_stall_pct = 63;
    foreach (plan[k]) offer_tick(plan[k].t, 1'b1, plan[k].want);
    drain_ticks();

    load_gains(random_bank());
    run_phase(90, 6, 63, 1'b0);

    // Integral-dominated pitch and yaw so that the integrators reach their clamps.
    bank = random_bank();
    bank.pitch_p = '0;
    bank.pitch_d = '0;
    bank.pitch_i = 16'($urandom_range(200, 900));
    bank.yaw_p   = '0;
    bank.yaw_d   = '0;
    bank.yaw_i   = 16'($urandom_range(200, 900));
    load_gains(bank);
    run_phase(160, 6, 63, 1'b0);

    load_gains('1);
    run_phase(70, 63, 6, 1'b0);

    load_gains('0);
    run_phase(30, 63, 6, 1'b0);

    load_gains(random_bank());
    run_phase(100, 0, 0, 1'b1);

    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_three_axis_attitude_pid_core: clean");
    end else begin
      $display("tb_three_axis_attitude_pid_core: errors");
    end
    $finish;
  end

endmodule

// ===== three_axis_attitude_pid_core.f =====
src/acp_pkg.sv
src/acp_cfg_regs.sv
src/acp_mac.sv
src/three_axis_attitude_pid_core.sv
src/acp_checker.sv
sim/tb_three_axis_attitude_pid_core.sv
